FILE: rtl/running_mean_segmenter_assert.svh
// Assertion macros for the running mean segmenter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RUNNING_MEAN_SEGMENTER_ASSERT_SVH
`define RUNNING_MEAN_SEGMENTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("running_mean_segmenter assertion failed");

// Next-cycle implication, disabled during reset.
`define RMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("running_mean_segmenter assertion failed");

`endif

FILE: rtl/rms_pkg.sv
// Shared types and constants of the running mean segmenter.
// No dependencies; imported by every module of the block.
package rms_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned DIVR_W    = CNT_W + 1;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MUL_Y_W   = CFG_W + 1;
  localparam int unsigned PROD_W    = SAMPLE_W + MUL_Y_W;

  localparam int unsigned COUNT_MAX = 65535;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned CMP_STEPS = 4;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_FRAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LIMIT    = 2'd1;

  localparam logic [CFG_W-1:0] DEVIATION_FRAC_RST = 8'd128;
  localparam logic [CFG_W-1:0] RATIO_LIMIT_RST    = 8'd20;

  // Join checks, one per compare step.
  localparam logic [1:0] CHK_DEV_HIGH  = 2'd0;
  localparam logic [1:0] CHK_DEV_LOW   = 2'd1;
  localparam logic [1:0] CHK_RATIO_LO  = 2'd2;
  localparam logic [1:0] CHK_RATIO_HI  = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                chunk_start;
    logic                average_valid;
    logic [SAMPLE_W-1:0] average;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_DECIDE,
    ST_FLUSH
  } rms_state_e;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       cmp_en;
    logic [1:0] cmp_idx;
    logic       decide;
    logic       flush;
  } rms_cmd_t;

  typedef struct packed {
    logic chunk_open;
    logic count_full;
    logic eos;
    logic out_free;
  } rms_status_t;

endpackage

FILE: rtl/rms_ctrl.sv
// Sequencer of the running mean segmenter: load, divide, compare, decide, flush.
// Depends on rms_pkg; drives the datapath by command structs only.
module rms_ctrl import rms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rms_status_t status_i,
  output rms_cmd_t    cmd_o
);

  rms_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          // First sample of a chunk or a full chunk needs no trial mean.
          if (!status_i.chunk_open || status_i.count_full) begin
            state_d = ST_DECIDE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_en  = 1'b1;
        cmd_o.cmp_idx = step_q[1:0];
        step_d        = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CMP_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = status_i.eos ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

endmodule

FILE: rtl/rms_dpath.sv
// Datapath of the running mean segmenter: chunk state, restoring divider,
// shared join-check multiplier, configuration and output register. Uses rms_pkg.
module rms_dpath import rms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_item_t             in_data_i,
  output out_item_t            out_data_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rms_cmd_t             cmd_i,
  output rms_status_t          status_o
);

  logic [CFG_W-1:0]    dev_q, ratio_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] mean_q, mean_d;
  logic                open_q, open_d;

  logic [SAMPLE_W-1:0] smp_q;
  logic                eos_q;
  logic [SUM_W-1:0]    tsum_q, dvd_q, quo_q;
  logic [DIVR_W-1:0]   div_q, rem_q, rem_d;
  logic                qbit;
  logic [DIVR_W:0]     part;
  logic                join_q;

  logic [SAMPLE_W-1:0] trial;
  logic [SAMPLE_W-1:0] mul_x;
  logic [MUL_Y_W-1:0]  mul_y;
  logic [PROD_W-1:0]   prod, lhs;
  logic                use_ge, chk_ok;
  logic                full;

  out_item_t           res_d, out_q;
  logic                out_valid_q;

  assign full  = (cnt_q >= CNT_W'(COUNT_MAX));
  assign trial = quo_q[SAMPLE_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= DEVIATION_FRAC_RST;
      ratio_q <= RATIO_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVIATION_FRAC: dev_q   <= cfg_data_i;
        CFG_RATIO_LIMIT:    ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One restoring divide step.
  always_comb begin
    part = {rem_q, dvd_q[SUM_W-1]};
    qbit = (part >= {1'b0, div_q});
    if (qbit) begin
      rem_d = DIVR_W'(part - {1'b0, div_q});
    end else begin
      rem_d = part[DIVR_W-1:0];
    end
  end

  // Shared multiplier for the four join checks.
  always_comb begin
    mul_x  = mean_q;
    mul_y  = {1'b0, ratio_q};
    lhs    = {{(PROD_W - SAMPLE_W - 8){1'b0}}, trial, 8'h00};
    use_ge = 1'b0;
    case (cmd_i.cmp_idx)
      CHK_DEV_HIGH: begin
        mul_y = {1'b0, dev_q} + MUL_Y_W'(256);
      end
      CHK_DEV_LOW: begin
        mul_y  = MUL_Y_W'(256) - {1'b0, dev_q};
        use_ge = 1'b1;
      end
      CHK_RATIO_LO: begin
        mul_x = smp_q;
        lhs   = {{(PROD_W - SAMPLE_W){1'b0}}, mean_q};
      end
      CHK_RATIO_HI: begin
        lhs = {{(PROD_W - SAMPLE_W){1'b0}}, smp_q};
      end
      default: ;
    endcase
    prod   = {{MUL_Y_W{1'b0}}, mul_x} * {{SAMPLE_W{1'b0}}, mul_y};
    chk_ok = use_ge ? (lhs >= prod) : (lhs <= prod);
  end

  // Item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q  <= in_data_i.sample;
      eos_q  <= in_data_i.end_of_sequence;
      tsum_q <= sum_q + {{(SUM_W - SAMPLE_W){1'b0}}, in_data_i.sample};
      dvd_q  <= sum_q + {{(SUM_W - SAMPLE_W){1'b0}}, in_data_i.sample};
      div_q  <= {1'b0, cnt_q} + DIVR_W'(1);
      rem_q  <= '0;
      quo_q  <= '0;
      join_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      quo_q <= {quo_q[SUM_W-2:0], qbit};
      rem_q <= rem_d;
    end else if (cmd_i.cmp_en) begin
      join_q <= join_q & chk_ok;
    end
  end

  // Chunk state update and result formation.
  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    mean_d = mean_q;
    open_d = open_q;
    res_d  = '0;
    res_d.sample_out = smp_q;
    if (cmd_i.decide) begin
      res_d.last = ~eos_q;
      if (open_q && join_q && !full) begin
        sum_d  = tsum_q;
        cnt_d  = cnt_q + CNT_W'(1);
        mean_d = trial;
      end else begin
        res_d.chunk_start   = 1'b1;
        res_d.average_valid = open_q;
        res_d.average       = open_q ? mean_q : '0;
        sum_d  = {{(SUM_W - SAMPLE_W){1'b0}}, smp_q};
        cnt_d  = CNT_W'(1);
        mean_d = smp_q;
        open_d = 1'b1;
      end
    end else if (cmd_i.flush) begin
      res_d.average_valid = 1'b1;
      res_d.average       = mean_q;
      res_d.last          = 1'b1;
      sum_d  = '0;
      cnt_d  = '0;
      mean_d = '0;
      open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      mean_q <= mean_d;
      open_q <= open_d;
      if (cmd_i.decide || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide || cmd_i.flush) begin
      out_q <= res_d;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign status_o.chunk_open = open_q;
  assign status_o.count_full = full;
  assign status_o.eos        = eos_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/running_mean_segmenter.sv
// Top level of the running mean segmenter: controller plus datapath.
// Depends on rms_pkg, rms_ctrl, rms_dpath and running_mean_segmenter_assert.svh.
//
// The block cuts a stream of unsigned Q16.16 samples into chunks by running
// mean and takes one sample transaction at a time. A sample that opens a chunk
// (first sample, first after a flush, or one arriving on a full chunk) skips
// the divider and goes from acceptance straight to the decide state, whose
// push registers its result. Any other sample runs the trial mean
// (chunk_sum + sample) / (chunk_count + 1) through a restoring divider that
// retires one quotient bit per cycle until all 48 quotient bits are done, then
// runs four join checks on one shared 32x9 multiplier before the decide push
// registers its result; the next sample is taken only once the block is back
// in idle. An end_of_sequence sample then passes through a flush state that
// pushes the final chunk average. Results land in an output register, so the
// next sample is accepted while a finished result still waits downstream; a
// result that finds the register full holds until it drains. Configuration is
// a plain write port: index 0 is deviation_frac, index 1 ratio_limit, other
// indexes are dropped.
`include "running_mean_segmenter_assert.svh"

module running_mean_segmenter import rms_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // sample input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  rms_cmd_t    cmd;
  rms_status_t status;

  // Sequence load, divide, compare, decide and flush.
  rms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold chunk state, divide, check the join rules, and register results.
  rms_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // Accepting a sample always leaves the block busy in the cycle after.
  `RMS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // Never overwrite a result that the consumer has not taken.
  `RMS_ASSERT_IMPL(a_push_when_free, cmd.decide || cmd.flush, !out_valid_o || out_ready_i)
  // A result appears only after a decide or flush push.
  `RMS_ASSERT_IMPL(a_out_from_push, $rose(out_valid_o), $past(cmd.decide || cmd.flush))

endmodule
